// ===== sv/srvramp_pkg.sv =====
// Shared types, codes and constant tables for the servo ramp controller.
// No dependencies; imported by every module of the block.
package srvramp_pkg;

    localparam int ANGLE_BITS_DEF = 8;
    // Widest angle the reciprocal table is sized for.
    localparam int ANGLE_BITS_MAX = 12;
    localparam int PCT_MAX        = 100;
    localparam int PCT_BITS       = 7;
    // 2^PCT_SHIFT > 100 * largest span, so the reciprocal floor is exact.
    localparam int PCT_SHIFT      = ANGLE_BITS_MAX + 7;
    localparam int RECIP_W        = PCT_SHIFT + 1;
    localparam int DELAY_BITS     = 5;
    localparam int SPEED_BITS     = 3;
    localparam int SETTLE_BITS    = 11;
    localparam int REQ_BITS       = 16;
    localparam int CFG_DATA_BITS  = 8;
    localparam int PORT_ANGLE_BITS = 8;

    typedef enum logic [1:0] {
        MODE_TICK  = 2'd0,
        MODE_PCT   = 2'd1,
        MODE_ANGLE = 2'd2,
        MODE_NONE  = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        CFG_MIN_ANGLE   = 2'd0,
        CFG_MAX_ANGLE   = 2'd1,
        CFG_MIRRORED    = 2'd2,
        CFG_SPEED_LEVEL = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic load_target;
        logic load_pct;
    } t_aim_ctl;

    typedef logic [PCT_MAX:0][RECIP_W-1:0] t_recip_tbl;

    // ceil(p * 2^PCT_SHIFT / 100), evaluated at elaboration
    function automatic t_recip_tbl build_recip();
        t_recip_tbl tbl;
        for (int i = 0; i <= PCT_MAX; i++) begin
            tbl[i] = RECIP_W'(((longint'(i) << PCT_SHIFT) + PCT_MAX - 1) / PCT_MAX);
        end
        return tbl;
    endfunction

    localparam t_recip_tbl PCT_RECIP = build_recip();

    function automatic logic [DELAY_BITS-1:0] step_delay(logic [SPEED_BITS-1:0] lvl);
        logic [DELAY_BITS-1:0] d;
        case (lvl)
            3'd0, 3'd1: d = 5'd30;
            3'd2:       d = 5'd25;
            3'd3:       d = 5'd20;
            3'd4:       d = 5'd15;
            3'd5:       d = 5'd10;
            default:    d = 5'd0;
        endcase
        return d;
    endfunction

    function automatic logic [SETTLE_BITS-1:0] settle_ms(logic [SPEED_BITS-1:0] lvl);
        logic [SETTLE_BITS-1:0] s;
        case (lvl)
            3'd0, 3'd1: s = 11'd1600;
            3'd2:       s = 11'd1400;
            3'd3:       s = 11'd1200;
            3'd4:       s = 11'd1000;
            3'd5:       s = 11'd800;
            default:    s = 11'd400;
        endcase
        return s;
    endfunction

endpackage

// ===== sv/srvramp_aim.sv =====
// Target computation: percent or angle command to a clamped target angle.
// Depends on srvramp_pkg.
module srvramp_aim #(
    parameter int ANGLE_BITS = srvramp_pkg::ANGLE_BITS_DEF
) (
    input  srvramp_pkg::t_mode          i_mode,
    input  logic signed [15:0]          i_percent_request,
    input  logic signed [15:0]          i_angle_request,
    input  logic [ANGLE_BITS-1:0]       i_min_angle,
    input  logic [ANGLE_BITS-1:0]       i_max_angle,
    input  logic                        i_mirrored,
    output logic [ANGLE_BITS-1:0]       o_target,
    output logic [6:0]                  o_percent,
    output srvramp_pkg::t_aim_ctl       o_ctl
);
    import srvramp_pkg::*;

    localparam int AW = ((ANGLE_BITS + 1 > REQ_BITS) ? ANGLE_BITS + 1 : REQ_BITS) + 2;
    localparam int PW = ANGLE_BITS + RECIP_W;

    logic [PCT_BITS-1:0]         pct_c;
    logic signed [ANGLE_BITS:0]  span;
    logic [ANGLE_BITS-1:0]       mag;
    logic [PW-1:0]               prod;
    logic [ANGLE_BITS-1:0]       quo;
    logic signed [AW-1:0]        lo;
    logic signed [AW-1:0]        hi;
    logic signed [AW-1:0]        offs;
    logic signed [AW-1:0]        pct_angle;
    logic signed [AW-1:0]        ang_ext;
    logic signed [AW-1:0]        a_sel;
    logic signed [AW-1:0]        a_mir;
    logic signed [AW-1:0]        a_clp;

    // clamp percent to 0..100
    always_comb begin
        if (i_percent_request > $signed(REQ_BITS'(PCT_MAX))) begin
            pct_c = PCT_BITS'(PCT_MAX);
        end else if (i_percent_request < 0) begin
            pct_c = '0;
        end else begin
            pct_c = i_percent_request[PCT_BITS-1:0];
        end
    end

    // span * pct / 100, truncated toward zero via reciprocal on the magnitude
    assign span = $signed({1'b0, i_max_angle}) - $signed({1'b0, i_min_angle});
    assign mag  = span[ANGLE_BITS] ? ANGLE_BITS'(-span) : span[ANGLE_BITS-1:0];
    assign prod = PW'(mag) * PW'(PCT_RECIP[pct_c]);
    assign quo  = ANGLE_BITS'(prod >> PCT_SHIFT);

    assign lo        = $signed(AW'(i_min_angle));
    assign hi        = $signed(AW'(i_max_angle));
    assign offs      = span[ANGLE_BITS] ? -$signed(AW'(quo)) : $signed(AW'(quo));
    assign pct_angle = lo + offs;
    assign ang_ext   = AW'(i_angle_request);

    assign a_sel = (i_mode == MODE_PCT) ? pct_angle : ang_ext;
    assign a_mir = i_mirrored ? (lo + hi - a_sel) : a_sel;

    always_comb begin
        if (a_mir < lo) begin
            a_clp = lo;
        end else if (a_mir > hi) begin
            a_clp = hi;
        end else begin
            a_clp = a_mir;
        end
    end

    assign o_target  = a_clp[ANGLE_BITS-1:0];
    assign o_percent = pct_c;

    always_comb begin
        unique case (i_mode)
            MODE_TICK:  o_ctl = '{load_target: 1'b0, load_pct: 1'b0};
            MODE_PCT:   o_ctl = '{load_target: 1'b1, load_pct: 1'b1};
            MODE_ANGLE: o_ctl = '{load_target: 1'b1, load_pct: 1'b0};
            MODE_NONE:  o_ctl = '{load_target: 1'b0, load_pct: 1'b0};
            default:    o_ctl = '{load_target: 1'b0, load_pct: 1'b0};
        endcase
    end

endmodule

// ===== sv/srvramp_step.sv =====
// Tick handling: step-delay countdown and one-degree output step.
// Depends on srvramp_pkg.
module srvramp_step #(
    parameter int ANGLE_BITS = srvramp_pkg::ANGLE_BITS_DEF
) (
    input  logic                                    i_tick,
    input  logic [ANGLE_BITS-1:0]                   i_output_deg,
    input  logic [ANGLE_BITS-1:0]                   i_target_deg,
    input  logic [srvramp_pkg::DELAY_BITS-1:0]      i_delay_left,
    input  logic [srvramp_pkg::SPEED_BITS-1:0]      i_speed_level,
    output logic [ANGLE_BITS-1:0]                   o_output_deg,
    output logic [srvramp_pkg::DELAY_BITS-1:0]      o_delay_left,
    output logic                                    o_moved
);
    import srvramp_pkg::*;

    logic [DELAY_BITS-1:0] dl_dec;

    assign dl_dec = (i_delay_left != '0) ? i_delay_left - DELAY_BITS'(1) : '0;

    always_comb begin
        o_output_deg = i_output_deg;
        o_delay_left = i_delay_left;
        o_moved      = 1'b0;
        if (i_tick) begin
            o_delay_left = dl_dec;
            if (dl_dec == '0 && i_output_deg != i_target_deg) begin
                if (i_output_deg > i_target_deg) begin
                    o_output_deg = i_output_deg - ANGLE_BITS'(1);
                end else begin
                    o_output_deg = i_output_deg + ANGLE_BITS'(1);
                end
                o_delay_left = step_delay(i_speed_level);
                o_moved      = 1'b1;
            end
        end
    end

endmodule

// ===== sv/servo_ramp_controller.sv =====
// Servo ramp controller: slews a servo angle one degree at a time toward a target.
// An accepted word passes through the input register, then the result register.
// Throughput: one word per cycle while the result side does not stall, no bubbles.
// Reset (synchronous, active low): target, output, delay and percent cleared,
// limits 0..180, mirroring off, speed level 0. Depends on srvramp_pkg,
// srvramp_aim and srvramp_step.
module servo_ramp_controller #(
    parameter int ANGLE_BITS = srvramp_pkg::ANGLE_BITS_DEF
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    // config write port
    input  logic                                        i_cfg_we,
    input  logic [1:0]                                  i_cfg_idx,
    input  logic [srvramp_pkg::CFG_DATA_BITS-1:0]       i_cfg_data,
    // input channel
    input  logic                                        i_valid,
    output logic                                        o_stall,
    input  logic [1:0]                                  i_mode,
    input  logic signed [srvramp_pkg::REQ_BITS-1:0]     i_percent_request,
    input  logic signed [srvramp_pkg::REQ_BITS-1:0]     i_angle_request,
    // result channel
    output logic                                        o_valid,
    input  logic                                        i_stall,
    output logic [srvramp_pkg::PORT_ANGLE_BITS-1:0]     o_servo_angle,
    output logic                                        o_moved,
    output logic [srvramp_pkg::PORT_ANGLE_BITS-1:0]     o_target_angle,
    output logic                                        o_at_target,
    output logic [srvramp_pkg::PCT_BITS-1:0]            o_last_percent,
    output logic [srvramp_pkg::SETTLE_BITS-1:0]         o_settle_time_ms
);
    import srvramp_pkg::*;

    localparam logic [ANGLE_BITS-1:0] MAX_ANGLE_RST = ANGLE_BITS'(180);

    // configuration
    logic [ANGLE_BITS-1:0]  r_min_angle;
    logic [ANGLE_BITS-1:0]  r_max_angle;
    logic                   r_mirrored;
    logic [SPEED_BITS-1:0]  r_speed_level;

    // input register
    logic                   r_in_valid;
    t_mode                  r_in_mode;
    logic signed [REQ_BITS-1:0] r_in_pct;
    logic signed [REQ_BITS-1:0] r_in_ang;

    // ramp state
    logic [ANGLE_BITS-1:0]  r_target_deg;
    logic [ANGLE_BITS-1:0]  r_output_deg;
    logic [DELAY_BITS-1:0]  r_delay_left;
    logic [PCT_BITS-1:0]    r_percent_seen;

    // result register
    logic                   r_out_valid;
    logic [PORT_ANGLE_BITS-1:0] r_servo_angle;
    logic                   r_moved;
    logic [PORT_ANGLE_BITS-1:0] r_target_angle;
    logic                   r_at_target;
    logic [PCT_BITS-1:0]    r_last_percent;
    logic [SETTLE_BITS-1:0] r_settle_time;

    logic                   fire;
    logic                   in_take;
    logic [ANGLE_BITS-1:0]  aim_target;
    logic [PCT_BITS-1:0]    aim_pct;
    t_aim_ctl               aim_ctl;
    logic [ANGLE_BITS-1:0]  n_output_deg;
    logic [DELAY_BITS-1:0]  n_delay_left;
    logic                   step_moved;
    logic [ANGLE_BITS-1:0]  n_target_deg;
    logic [PCT_BITS-1:0]    n_percent_seen;

    // The held word moves into the result register whenever that register
    // is empty or being drained; upstream stalls only when both are blocked.
    assign fire    = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_in_valid && r_out_valid && i_stall;
    assign in_take = i_valid && !o_stall;

    srvramp_aim #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_aim (
        .i_mode            (r_in_mode),
        .i_percent_request (r_in_pct),
        .i_angle_request   (r_in_ang),
        .i_min_angle       (r_min_angle),
        .i_max_angle       (r_max_angle),
        .i_mirrored        (r_mirrored),
        .o_target          (aim_target),
        .o_percent         (aim_pct),
        .o_ctl             (aim_ctl)
    );

    // Ticks only look at the target held before this word; commands never
    // touch the output or the delay counter.
    srvramp_step #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_step (
        .i_tick        (r_in_mode == MODE_TICK),
        .i_output_deg  (r_output_deg),
        .i_target_deg  (r_target_deg),
        .i_delay_left  (r_delay_left),
        .i_speed_level (r_speed_level),
        .o_output_deg  (n_output_deg),
        .o_delay_left  (n_delay_left),
        .o_moved       (step_moved)
    );

    assign n_target_deg   = aim_ctl.load_target ? aim_target : r_target_deg;
    assign n_percent_seen = aim_ctl.load_pct ? aim_pct : r_percent_seen;

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_angle   <= '0;
            r_max_angle   <= MAX_ANGLE_RST;
            r_mirrored    <= 1'b0;
            r_speed_level <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_MIN_ANGLE:   r_min_angle   <= ANGLE_BITS'(i_cfg_data);
                CFG_MAX_ANGLE:   r_max_angle   <= ANGLE_BITS'(i_cfg_data);
                CFG_MIRRORED:    r_mirrored    <= i_cfg_data[0];
                CFG_SPEED_LEVEL: r_speed_level <= i_cfg_data[SPEED_BITS-1:0];
                default:         r_mirrored    <= r_mirrored;
            endcase
        end
    end

    // handshake and state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
            r_target_deg   <= '0;
            r_output_deg   <= '0;
            r_delay_left   <= '0;
            r_percent_seen <= '0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (fire) begin
                r_in_valid <= 1'b0;
            end
            if (fire) begin
                r_out_valid    <= 1'b1;
                r_target_deg   <= n_target_deg;
                r_output_deg   <= n_output_deg;
                r_delay_left   <= n_delay_left;
                r_percent_seen <= n_percent_seen;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_mode <= t_mode'(i_mode);
            r_in_pct  <= i_percent_request;
            r_in_ang  <= i_angle_request;
        end
        if (fire) begin
            r_servo_angle  <= n_output_deg[PORT_ANGLE_BITS-1:0];
            r_moved        <= step_moved;
            r_target_angle <= n_target_deg[PORT_ANGLE_BITS-1:0];
            r_at_target    <= (n_output_deg == n_target_deg);
            r_last_percent <= n_percent_seen;
            r_settle_time  <= settle_ms(r_speed_level);
        end
    end

    assign o_valid          = r_out_valid;
    assign o_servo_angle    = r_servo_angle;
    assign o_moved          = r_moved;
    assign o_target_angle   = r_target_angle;
    assign o_at_target      = r_at_target;
    assign o_last_percent   = r_last_percent;
    assign o_settle_time_ms = r_settle_time;

endmodule

// ===== sim/servo_ramp_controller_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for servo_ramp_controller: random commands and ticks
// checked against a built-in ramp tracker. Depends on srvramp_pkg and the RTL.
module servo_ramp_controller_tb;
    import srvramp_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RAND_SETS    = 14;   // config settings in the random part
    localparam int WORDS_PER_SET = 48;
    localparam int CALM_SETS    = 3;    // last settings run without idling
    localparam int REPORT_MAX   = 10;

    // One result word, as the block presents it.
    typedef struct packed {
        logic [PORT_ANGLE_BITS-1:0] angle;
        logic                       moved;
        logic [PORT_ANGLE_BITS-1:0] target;
        logic                       at_target;
        logic [PCT_BITS-1:0]        pct;
        logic [SETTLE_BITS-1:0]     settle;
    } t_ramp_word;

    // Tracks limits, target, position and step delay; queues the expected words.
    class t_ramp_tracker;
        logic [PORT_ANGLE_BITS-1:0] lo_deg, hi_deg;
        bit                         mirror;
        logic [SPEED_BITS-1:0]      speed;
        logic [PORT_ANGLE_BITS-1:0] target, position;
        logic [DELAY_BITS-1:0]      delay;
        logic [PCT_BITS-1:0]        pct;
        t_ramp_word                 due_words[$];
        int                         errors, checked, steps;
        int unsigned                step_ms[8]   = '{30, 30, 25, 20, 15, 10, 0, 0};
        int unsigned                travel_ms[8] = '{1600, 1600, 1400, 1200, 1000, 800,
                                                     400, 400};

        function new();
            lo_deg   = 0;
            hi_deg   = 180;
            mirror   = 0;
            speed    = 0;
            target   = 0;
            position = 0;
            delay    = 0;
            pct      = 0;
            errors   = 0;
            checked  = 0;
            steps    = 0;
        endfunction

        function void write_reg(t_cfg_idx idx, logic [CFG_DATA_BITS-1:0] data);
            case (idx)
                CFG_MIN_ANGLE:   lo_deg = data;
                CFG_MAX_ANGLE:   hi_deg = data;
                CFG_MIRRORED:    mirror = data[0];
                CFG_SPEED_LEVEL: speed  = data[SPEED_BITS-1:0];
                default: ;
            endcase
        endfunction

        // mirror, then clamp low side first (matters when limits are reversed)
        function void aim(int a);
            int lo, hi, t;
            lo = int'(lo_deg);
            hi = int'(hi_deg);
            if (mirror)
                a = lo - a + hi;
            if (a < lo)
                t = lo;
            else if (a > hi)
                t = hi;
            else
                t = a;
            target = t[PORT_ANGLE_BITS-1:0];
        endfunction

        function void note_command(t_mode m, logic signed [REQ_BITS-1:0] p_req,
                                   logic signed [REQ_BITS-1:0] a_req);
            t_ramp_word w;
            int         p, span;
            bit         stepped;
            stepped = 0;
            case (m)
                MODE_TICK: begin
                    if (delay > 0)
                        delay = delay - 1'b1;
                    if (delay == 0 && position != target) begin
                        position = (position > target) ? position - 1'b1 : position + 1'b1;
                        delay    = DELAY_BITS'(step_ms[speed]);
                        stepped  = 1;
                    end
                end
                MODE_PCT: begin
                    p = int'(p_req);
                    if (p > 100)
                        p = 100;
                    if (p < 0)
                        p = 0;
                    pct  = p[PCT_BITS-1:0];
                    span = int'(hi_deg) - int'(lo_deg);
                    aim(int'(lo_deg) + (span * p) / 100);   // truncates toward zero
                end
                MODE_ANGLE: aim(int'(a_req));
                default: ;
            endcase
            w.angle     = position;
            w.moved     = stepped;
            w.target    = target;
            w.at_target = (position == target);
            w.pct       = pct;
            w.settle    = SETTLE_BITS'(travel_ms[speed]);
            due_words.push_back(w);
        endfunction

        function void check_word(t_ramp_word got);
            t_ramp_word exp;
            bit         bad;
            if (due_words.size() == 0) begin
                errors++;
                if (errors <= REPORT_MAX)
                    $display("ERROR: result word with nothing pending: angle %0d target %0d",
                             got.angle, got.target);
                return;
            end
            exp = due_words.pop_front();
            checked++;
            if (got.moved === 1'b1)
                steps++;
            bad = (got.angle !== exp.angle) || (got.moved !== exp.moved) ||
                  (got.target !== exp.target) || (got.at_target !== exp.at_target) ||
                  (got.pct !== exp.pct) || (got.settle !== exp.settle);
            if (bad) begin
                errors++;
                if (errors <= REPORT_MAX)
                    $display({"ERROR: word %0d exp/got angle %0d/%0d moved %0b/%0b ",
                              "target %0d/%0d at %0b/%0b pct %0d/%0d settle %0d/%0d"},
                             checked, exp.angle, got.angle, exp.moved, got.moved,
                             exp.target, got.target, exp.at_target, got.at_target,
                             exp.pct, got.pct, exp.settle, got.settle);
            end
        endfunction
    endclass

    logic                            i_clk = 1'b0;
    logic                            i_rst_n;
    logic                            i_cfg_we;
    logic [1:0]                      i_cfg_idx;
    logic [CFG_DATA_BITS-1:0]        i_cfg_data;
    logic                            i_valid;
    logic                            o_stall;
    logic [1:0]                      i_mode;
    logic signed [REQ_BITS-1:0]      i_percent_request;
    logic signed [REQ_BITS-1:0]      i_angle_request;
    logic                            o_valid;
    logic                            i_stall;
    logic [PORT_ANGLE_BITS-1:0]      o_servo_angle;
    logic                            o_moved;
    logic [PORT_ANGLE_BITS-1:0]      o_target_angle;
    logic                            o_at_target;
    logic [PCT_BITS-1:0]             o_last_percent;
    logic [SETTLE_BITS-1:0]          o_settle_time_ms;

    t_ramp_tracker tracker;
    bit          src_gaps_on  = 1'b1;  // random valid gaps on the input side
    bit          sink_gaps_on = 1'b1;  // random stall bursts on the result side
    int          cycles       = 0;
    int          words_sent   = 0;
    int          settings_run = 0;

    servo_ramp_controller dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_mode            (i_mode),
        .i_percent_request (i_percent_request),
        .i_angle_request   (i_angle_request),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_servo_angle     (o_servo_angle),
        .o_moved           (o_moved),
        .o_target_angle    (o_target_angle),
        .o_at_target       (o_at_target),
        .o_last_percent    (o_last_percent),
        .o_settle_time_ms  (o_settle_time_ms)
    );

    always #1 i_clk = ~i_clk;

    // Watchdog: a hung handshake ends the run here.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("servo_ramp_controller_tb: FAIL");
            $finish;
        end
    end

    // Result side: random stall bursts, changed on the falling edge.
    initial begin
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (sink_gaps_on && $urandom_range(0, 7) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 10)) @(negedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    // Result monitor: every accepted word goes to the tracker.
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_valid === 1'b1 && i_stall === 1'b0)
            tracker.check_word('{o_servo_angle, o_moved, o_target_angle, o_at_target,
                                 o_last_percent, o_settle_time_ms});
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    // Valid is left high so back-to-back words need no extra assignment.
    task automatic send_word(t_mode m, logic signed [REQ_BITS-1:0] p_req,
                             logic signed [REQ_BITS-1:0] a_req);
        int gap;
        if (src_gaps_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 10);
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid           <= 1'b1;
        i_mode            <= m;
        i_percent_request <= p_req;
        i_angle_request   <= a_req;
        do
            @(posedge i_clk);
        while (o_stall !== 1'b0);
        tracker.note_command(m, p_req, a_req);
        words_sent++;
        @(negedge i_clk);
    endtask

    // Drop valid and let every pending result drain before touching registers.
    task automatic wait_drained();
        i_valid <= 1'b0;
        while (tracker.due_words.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_BITS-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        tracker.write_reg(idx, data);
        @(negedge i_clk);
    endtask

    task automatic apply_setting(logic [7:0] lo, logic [7:0] hi, bit mir,
                                 logic [SPEED_BITS-1:0] spd);
        write_reg(CFG_MIN_ANGLE, lo);
        write_reg(CFG_MAX_ANGLE, hi);
        write_reg(CFG_MIRRORED, CFG_DATA_BITS'(mir));
        write_reg(CFG_SPEED_LEVEL, CFG_DATA_BITS'(spd));
        i_cfg_we <= 1'b0;
        settings_run++;
    endtask

    // Mostly in or near 0..100, sometimes any 16-bit value.
    function automatic logic signed [REQ_BITS-1:0] pick_percent();
        case ($urandom_range(0, 9))
            0:       return REQ_BITS'($urandom);
            1:       return -REQ_BITS'($urandom_range(1, 300));
            default: return REQ_BITS'($urandom_range(0, 115));
        endcase
    endfunction

    // Mostly around the servo range, sometimes any 16-bit value.
    function automatic logic signed [REQ_BITS-1:0] pick_angle();
        case ($urandom_range(0, 9))
            0:       return REQ_BITS'($urandom);
            1:       return REQ_BITS'($urandom_range(0, 700)) - REQ_BITS'(300);
            default: return REQ_BITS'($urandom_range(0, 190));
        endcase
    endfunction

    // Ticks dominate so the ramp actually travels between commands.
    task automatic send_random_word();
        int r;
        r = $urandom_range(0, 19);
        if (r < 11)
            send_word(MODE_TICK, REQ_BITS'($urandom), REQ_BITS'($urandom));
        else if (r < 14)
            send_word(MODE_PCT, pick_percent(), REQ_BITS'($urandom));
        else if (r < 19)
            send_word(MODE_ANGLE, REQ_BITS'($urandom), pick_angle());
        else
            send_word(MODE_NONE, REQ_BITS'($urandom), REQ_BITS'($urandom));
    endtask

    initial begin
        logic [7:0] lo, hi, t;
        tracker           = new();
        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_idx         = CFG_MIN_ANGLE;
        i_cfg_data        = '0;
        i_valid           = 1'b0;
        i_mode            = MODE_TICK;
        i_percent_request = '0;
        i_angle_request   = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part at reset limits 0..180, no mirroring, 30 ms steps.
        send_word(MODE_TICK, '0, '0);             // already on target
        send_word(MODE_PCT, 16'sd100, '0);
        send_word(MODE_PCT, 16'h7FFF, '0);        // clamps to 100
        send_word(MODE_PCT, 16'h8000, '0);        // clamps to 0
        send_word(MODE_PCT, 16'sd101, '0);
        send_word(MODE_PCT, 16'hFFFF, '0);        // -1
        send_word(MODE_PCT, 16'sd50, '0);
        send_word(MODE_PCT, 16'sd1, '0);
        send_word(MODE_PCT, 16'sd99, '0);
        send_word(MODE_ANGLE, '0, 16'h8000);
        send_word(MODE_ANGLE, '0, 16'h7FFF);
        send_word(MODE_ANGLE, '0, 16'sd181);
        send_word(MODE_ANGLE, '0, 16'sd180);
        send_word(MODE_ANGLE, '0, 16'hFFFF);
        send_word(MODE_ANGLE, '0, 16'sd0);
        send_word(MODE_ANGLE, 16'h7FFF, 16'sd90);
        send_word(MODE_NONE, 16'hFFFF, 16'hFFFF);  // unused mode: nothing moves
        send_word(MODE_NONE, 16'h0000, 16'h0000);
        repeat (4) send_word(MODE_TICK, 16'hFFFF, 16'hFFFF);  // first tick steps at once
        send_word(MODE_PCT, 16'sd0, 16'sd45);     // command leaves delay alone
        send_word(MODE_TICK, '0, '0);
        wait_drained();

        // Random part: hand-picked extremes first, then random settings.
        for (int s = 0; s < RAND_SETS; s++) begin
            if (s >= RAND_SETS - CALM_SETS) begin
                src_gaps_on  = 1'b0;
                sink_gaps_on = 1'b0;
            end
            case (s)
                0: apply_setting(8'd0,   8'd180, 1'b0, 3'd6);   // zero delay
                1: apply_setting(8'd180, 8'd0,   1'b0, 3'd2);   // reversed limits
                2: apply_setting(8'd0,   8'd180, 1'b1, 3'd7);
                3: apply_setting(8'd180, 8'd180, 1'b1, 3'd1);
                4: apply_setting(8'd0,   8'd0,   1'b0, 3'd5);
                5: apply_setting(8'd20,  8'd160, 1'b1, 3'd3);
                6: apply_setting(8'd150, 8'd30,  1'b1, 3'd4);   // reversed and mirrored
                default: begin
                    lo = 8'($urandom_range(0, 180));
                    hi = 8'($urandom_range(0, 180));
                    if (lo > hi && $urandom_range(0, 3) != 0) begin
                        t  = lo;
                        lo = hi;
                        hi = t;
                    end
                    apply_setting(lo, hi, 1'($urandom_range(0, 1)),
                                  SPEED_BITS'($urandom_range(0, 7)));
                end
            endcase
            repeat (WORDS_PER_SET) send_random_word();
            wait_drained();
        end

        repeat (10) @(posedge i_clk);
        tracker.errors += tracker.due_words.size();
        $display("Run covered %0d words over %0d register settings plus reset values;",
                 words_sent, settings_run);
        $display("%0d result words checked, %0d of them one-degree steps, %0d errors.",
                 tracker.checked, tracker.steps, tracker.errors);
        if (tracker.errors == 0)
            $display("servo_ramp_controller_tb: PASS");
        else
            $display("servo_ramp_controller_tb: FAIL");
        $finish;
    end

endmodule
